>>> rtl/core/crc_pkg.sv
package crc_pkg;

  localparam int unsigned PosFracDef  = 8;
  localparam int unsigned NormFracDef = 14;

  // Width of the arithmetic in each digit-recurrence lane. It covers the
  // largest normal precision: q^2 * dsq with q below 2^22 and dsq below 2^33.
  localparam int unsigned LaneW = 88;
  localparam int unsigned RootW = 24;

  localparam int unsigned NumLanes = 3;
  localparam int unsigned LaneSqrt = 0;
  localparam int unsigned LaneX    = 1;
  localparam int unsigned LaneY    = 2;

  typedef struct packed {
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic        [15:0] radius;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic        [14:0] rect_width;
    logic        [14:0] rect_height;
  } crc_req_t;

  typedef struct packed {
    logic               hit;
    logic               center_inside;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic        [15:0] depth;
  } crc_rsp_t;

  // One lane finds the largest root with root^2 * den <= num.
  // acc holds root^2 * den and lin holds root * den.
  typedef struct packed {
    logic [LaneW-1:0] num;
    logic [LaneW-1:0] den;
    logic [LaneW-1:0] acc;
    logic [LaneW-1:0] lin;
    logic [RootW-1:0] root;
  } crc_lane_t;

  typedef struct packed {
    logic        vld;
    logic        hit;
    logic        ctr_in;
    logic        neg_x;
    logic        neg_y;
    logic [15:0] radius;
    logic [32:0] dsq;
  } crc_side_t;

endpackage

>>> rtl/core/circle_rect_collision.sv
// Circle against axis-aligned rectangle test, fully pipelined. A request
// carries a circle center and radius in fixed point and a rectangle in
// whole units; every request yields exactly one response with a hit flag,
// a center-inside flag, the truncated unit push-out normal and the
// penetration depth (all zero on a miss; on a center-inside hit the normal
// is zero and the depth equals the radius). The block accepts one request
// per clock cycle while in_stall_o is low and delivers responses in order.
// Three front stages find the nearest point, square the offsets and test
// the distance, then a chain of identical cells resolves one root bit per
// cycle for the square root of the distance and for both normal
// components, and a final register holds the response. The whole pipeline
// holds only while a finished response is stalled at the output.
module circle_rect_collision import crc_pkg::*; #(
  parameter int unsigned POS_FRAC_BITS    = PosFracDef,
  parameter int unsigned NORMAL_FRAC_BITS = NormFracDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  crc_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output crc_rsp_t out_rsp_o
);

  // The chain must cover both the 16-bit distance root and the normal
  // quotient, which has NORMAL_FRAC_BITS + 2 bits.
  localparam int unsigned Cells = (NORMAL_FRAC_BITS + 2 > 16) ? NORMAL_FRAC_BITS + 2 : 16;

  logic out_vld_q;
  logic adv;

  // Everything moves forward unless the held response is being stalled.
  assign adv        = !(out_vld_q && out_stall_i);
  assign in_stall_o = !adv;

  crc_side_t side_w [Cells+1];
  crc_lane_t lane_w [Cells+1][NumLanes];

  crc_front #(
    .POS_FRAC_BITS    (POS_FRAC_BITS),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (in_valid_i && adv),
    .req_i  (in_req_i),
    .side_o (side_w[0]),
    .lane_o (lane_w[0])
  );

  // The first cell decides the most significant root bit.
  for (genvar k = 0; k < Cells; k++) begin : g_cell
    crc_cell #(
      .BIT (Cells - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .side_i (side_w[k]),
      .lane_i (lane_w[k]),
      .side_o (side_w[k+1]),
      .lane_o (lane_w[k+1])
    );
  end

  crc_side_t fin;
  crc_rsp_t  rsp_d;
  crc_rsp_t  rsp_q;
  logic [16:0] root_ceil;
  logic [15:0] mag_x, mag_y;

  // The sqrt lane ends with acc equal to the floored root squared, so a
  // mismatch with the distance means the root must be rounded up.
  always_comb begin
    fin       = side_w[Cells];
    root_ceil = {1'b0, lane_w[Cells][LaneSqrt].root[15:0]}
                + 17'(lane_w[Cells][LaneSqrt].acc != LaneW'(fin.dsq));
    mag_x     = lane_w[Cells][LaneX].root[15:0];
    mag_y     = lane_w[Cells][LaneY].root[15:0];
    rsp_d     = '0;
    if (fin.hit) begin
      rsp_d.hit = 1'b1;
      if (fin.ctr_in) begin
        rsp_d.center_inside = 1'b1;
        rsp_d.depth         = fin.radius;
      end else begin
        rsp_d.depth    = 16'({1'b0, fin.radius} - root_ceil);
        rsp_d.normal_x = fin.neg_x ? 16'(-mag_x) : mag_x;
        rsp_d.normal_y = fin.neg_y ? 16'(-mag_y) : mag_y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= fin.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = rsp_q;

`ifndef SYNTHESIS
  // A miss carries no normal, no depth and no inside flag.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !rsp_q.hit) |-> (rsp_q.depth == '0 && rsp_q.normal_x == '0
      && rsp_q.normal_y == '0 && !rsp_q.center_inside))
    else $error("miss response with nonzero fields");

  // A center-inside response is a hit with a zero normal.
  a_inside_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && rsp_q.center_inside) |-> (rsp_q.hit && rsp_q.normal_x == '0
      && rsp_q.normal_y == '0))
    else $error("center-inside response with a normal");

  // A held response must not be replaced while the pipeline is frozen.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> (out_vld_q && $stable(rsp_q)
      && $stable(side_w[Cells])))
    else $error("pipeline advanced while the response was stalled");
`endif

endmodule

>>> rtl/core/crc_cell.sv
module crc_cell import crc_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  crc_side_t side_i,
  input  crc_lane_t lane_i [NumLanes],
  output crc_side_t side_o,
  output crc_lane_t lane_o [NumLanes]
);

  crc_side_t side_q;
  crc_lane_t lane_q [NumLanes];
  crc_lane_t lane_d [NumLanes];

  // Each cell decides one root bit in every lane.
  always_comb begin
    logic [LaneW-1:0] trial;
    for (int i = 0; i < NumLanes; i++) begin
      lane_d[i] = lane_i[i];
      trial = lane_i[i].acc + (lane_i[i].lin << (BIT + 1)) + (lane_i[i].den << (2 * BIT));
      if (trial <= lane_i[i].num) begin
        lane_d[i].acc  = trial;
        lane_d[i].lin  = lane_i[i].lin + (lane_i[i].den << BIT);
        lane_d[i].root = lane_i[i].root | (RootW'(1) << BIT);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (adv_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lane_q <= lane_d;
    end
  end

  assign side_o = side_q;
  assign lane_o = lane_q;

endmodule

>>> rtl/core/crc_front.sv
module crc_front import crc_pkg::*; #(
  parameter int unsigned POS_FRAC_BITS    = PosFracDef,
  parameter int unsigned NORMAL_FRAC_BITS = NormFracDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  logic      vld_i,
  input  crc_req_t  req_i,
  output crc_side_t side_o,
  output crc_lane_t lane_o [NumLanes]
);

  localparam int unsigned EdgeW = 17 + POS_FRAC_BITS;
  localparam int unsigned CoordW = ((EdgeW > 24) ? EdgeW : 24) + 2;

  logic signed [CoordW-1:0] cx, cy, lo_x, hi_x, lo_y, hi_y, nx, ny, dx, dy;
  logic        [CoordW-1:0] adx, ady;

  // Stage A: nearest point and offset.
  always_comb begin
    cx   = CoordW'(req_i.center_x);
    cy   = CoordW'(req_i.center_y);
    lo_x = CoordW'(req_i.rect_left) <<< POS_FRAC_BITS;
    lo_y = CoordW'(req_i.rect_top) <<< POS_FRAC_BITS;
    hi_x = (CoordW'(req_i.rect_left) + CoordW'($signed({1'b0, req_i.rect_width})))
           <<< POS_FRAC_BITS;
    hi_y = (CoordW'(req_i.rect_top) + CoordW'($signed({1'b0, req_i.rect_height})))
           <<< POS_FRAC_BITS;
    nx = (cx > hi_x) ? hi_x : cx;
    nx = (nx < lo_x) ? lo_x : nx;
    ny = (cy > hi_y) ? hi_y : cy;
    ny = (ny < lo_y) ? lo_y : ny;
    dx = cx - nx;
    dy = cy - ny;
    adx = dx[CoordW-1] ? CoordW'(-dx) : CoordW'(dx);
    ady = dy[CoordW-1] ? CoordW'(-dy) : CoordW'(dy);
  end

  logic        a_vld_q, a_far_q, a_negx_q, a_negy_q;
  logic [15:0] a_dx_q, a_dy_q, a_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv_i) begin
      a_vld_q <= vld_i;
    end
  end

  // An offset of 2^16 or more squares past any radius, so it can never hit.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_far_q  <= (|adx[CoordW-1:16]) | (|ady[CoordW-1:16]);
      a_negx_q <= dx[CoordW-1];
      a_negy_q <= dy[CoordW-1];
      a_dx_q   <= adx[15:0];
      a_dy_q   <= ady[15:0];
      a_r_q    <= req_i.radius;
    end
  end

  // Stage B: squares.
  logic        b_vld_q, b_far_q, b_negx_q, b_negy_q;
  logic [31:0] b_dx2_q, b_dy2_q, b_rr_q;
  logic [15:0] b_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv_i) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_far_q  <= a_far_q;
      b_negx_q <= a_negx_q;
      b_negy_q <= a_negy_q;
      b_dx2_q  <= a_dx_q * a_dx_q;
      b_dy2_q  <= a_dy_q * a_dy_q;
      b_rr_q   <= a_r_q * a_r_q;
      b_r_q    <= a_r_q;
    end
  end

  // Stage C: distance test and lane setup.
  crc_side_t side_d;
  crc_lane_t lane_d [NumLanes];
  logic [32:0] dsq;

  always_comb begin
    dsq = {1'b0, b_dx2_q} + {1'b0, b_dy2_q};
    side_d.vld    = b_vld_q;
    side_d.hit    = !b_far_q && (dsq < {1'b0, b_rr_q});
    side_d.ctr_in = side_d.hit && (dsq == '0);
    side_d.neg_x  = b_negx_q;
    side_d.neg_y  = b_negy_q;
    side_d.radius = b_r_q;
    side_d.dsq    = dsq;
    for (int i = 0; i < NumLanes; i++) begin
      lane_d[i] = '0;
    end
    if (side_d.hit) begin
      lane_d[LaneSqrt].num = LaneW'(dsq);
      lane_d[LaneSqrt].den = LaneW'(1);
      lane_d[LaneX].num    = LaneW'(b_dx2_q) << (2 * NORMAL_FRAC_BITS);
      lane_d[LaneX].den    = LaneW'(dsq);
      lane_d[LaneY].num    = LaneW'(b_dy2_q) << (2 * NORMAL_FRAC_BITS);
      lane_d[LaneY].den    = LaneW'(dsq);
    end
  end

  crc_side_t side_q;
  crc_lane_t lane_q [NumLanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (adv_i) begin
      side_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lane_q <= lane_d;
    end
  end

  assign side_o = side_q;
  assign lane_o = lane_q;

endmodule
